// ===== rtl/fb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fb_pkg
// Shared types, constants and the CRC-16 byte update for the frame builder.
// ----------------------------------------------------------------------------
package fb_pkg;

  localparam int FRAME_MAX = 1024;
  localparam int HDR_BYTES = 4;
  localparam int CRC_BYTES = 2;
  localparam int LEN_W     = 10;
  localparam int SUM_W     = 17;   // holds frame length plus framing up to FRAME_MAX range

  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [7:0]  START_RESET = 8'hAA;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QCW    = 3;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ZERO_LEN = 3'd1,
    ST_TOO_LONG = 3'd2,
    ST_OPEN     = 3'd3,
    ST_MISMATCH = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CMD_ERR  = 2'd0,
    CMD_HEAD = 2'd1,
    CMD_DATA = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    status_t           status;
    logic              crc_tail;
    logic [7:0]        ftype;
    logic [LEN_W-1:0]  flen;
    logic [7:0]        data;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_CMD  = 3'd0,
    BK_TYPE = 3'd1,
    BK_LENH = 3'd2,
    BK_LENL = 3'd3,
    BK_DATA = 3'd4,
    BK_CRCH = 3'd5,
    BK_CRCL = 3'd6
  } bk_state_t;

  // MSB-first CRC-16 update over one byte
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/fb_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fb_in_if
// Input channel: one payload byte per transaction with frame markers.
// ----------------------------------------------------------------------------
interface fb_in_if;
  logic       valid;
  logic       ready;
  logic       first;
  logic       last;
  logic [7:0] frame_type;
  logic [9:0] frame_len;
  logic [7:0] data_byte;

  modport source (output valid, first, last, frame_type, frame_len, data_byte,
                  input ready);
  modport sink   (input valid, first, last, frame_type, frame_len, data_byte,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/fb_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fb_out_if
// Result channel: one frame byte or one error result per transaction.
// ----------------------------------------------------------------------------
interface fb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_frame;
  logic [2:0] status;

  modport source (output valid, out_byte, end_of_frame, status, input ready);
  modport sink   (input valid, out_byte, end_of_frame, status, output ready);
endinterface
`default_nettype wire

// ===== rtl/fb_cfg_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fb_cfg_if
// Configuration write channel for the start-of-frame byte.
// ----------------------------------------------------------------------------
interface fb_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/fb_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fb_front
// Accepts input bytes, checks them against the open frame and queues commands.
// ----------------------------------------------------------------------------
module fb_front import fb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  fb_in_if.sink     in_ch,
  output cmd_t      cmd,
  output logic      push,
  input  wire logic q_full
);

  logic             open_r, open_nxt;
  logic [LEN_W-1:0] left_r, left_nxt;
  logic             accept;
  logic [SUM_W-1:0] len_sum;
  logic             too_long;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign push        = accept;

  assign len_sum  = SUM_W'(in_ch.frame_len) + SUM_W'(HDR_BYTES + CRC_BYTES);
  assign too_long = len_sum > SUM_W'(FRAME_MAX);

  always_comb begin
    open_nxt     = open_r;
    left_nxt     = left_r;
    cmd.kind     = CMD_ERR;
    cmd.status   = ST_MISMATCH;
    cmd.crc_tail = in_ch.last;
    cmd.ftype    = in_ch.frame_type;
    cmd.flen     = in_ch.frame_len;
    cmd.data     = in_ch.data_byte;
    if (in_ch.first) begin
      if (in_ch.frame_len == '0) begin
        cmd.status = ST_ZERO_LEN;
      end else if (open_r) begin
        cmd.status = ST_OPEN;          // leave the open frame alone
      end else if (too_long) begin
        cmd.status = ST_TOO_LONG;
      end else if (in_ch.last && in_ch.frame_len != LEN_W'(1)) begin
        cmd.status = ST_MISMATCH;
      end else begin
        cmd.kind   = CMD_HEAD;
        cmd.status = ST_OK;
        open_nxt   = !in_ch.last;
        left_nxt   = in_ch.last ? '0 : in_ch.frame_len - LEN_W'(1);
      end
    end else if (open_r) begin
      if (left_r == '0 || (in_ch.last && left_r != LEN_W'(1))) begin
        open_nxt = 1'b0;               // drop the frame
        left_nxt = '0;
      end else begin
        cmd.kind   = CMD_DATA;
        cmd.status = ST_OK;
        left_nxt   = left_r - LEN_W'(1);
        if (in_ch.last) begin
          open_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      left_r <= '0;
    end else if (accept) begin
      open_r <= open_nxt;
      left_r <= left_nxt;
    end
  end

  a_closed_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !open_r |-> left_r == '0)
    else $error("closed frame still counts bytes");

  a_open_kept: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.first && open_r |=> open_r)
    else $error("second start closed the open frame");

endmodule
`default_nettype wire

// ===== rtl/fb_cmd_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fb_cmd_fifo
// Short command queue between the front and the back end.
// ----------------------------------------------------------------------------
module fb_cmd_fifo import fb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output cmd_t      head,
  output logic      head_valid
);

  cmd_t           mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] rd_ptr_r;
  logic [QCW-1:0] cnt_r, cnt_nxt;

  assign full       = cnt_r == QCW'(QDEPTH);
  assign head_valid = cnt_r != '0;
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full || pop)
    else $error("command queue overflow");

endmodule
`default_nettype wire

// ===== rtl/fb_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fb_back
// Expands queued commands into frame bytes, runs the CRC, drives the output.
// ----------------------------------------------------------------------------
module fb_back import fb_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cmd_t       cmd,
  input  wire logic       q_valid,
  output logic            q_pop,
  input  wire logic [7:0] start_byte,
  fb_out_if.source        out_ch
);

  bk_state_t   st_r, st_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        out_valid_r;
  logic [7:0]  byte_r;
  logic        eof_r;
  status_t     status_r;

  logic        slot_free;
  logic        fire;
  logic [7:0]  byte_v;
  logic        eof_v;
  status_t     status_v;
  logic        feed;
  logic        restart;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign fire      = q_valid && slot_free;

  // next state
  always_comb begin
    st_nxt = st_r;
    if (fire) begin
      case (st_r)
        BK_CMD: begin
          case (cmd.kind)
            CMD_HEAD: st_nxt = BK_TYPE;
            CMD_DATA: st_nxt = cmd.crc_tail ? BK_CRCH : BK_CMD;
            default:  st_nxt = BK_CMD;
          endcase
        end
        BK_TYPE: st_nxt = BK_LENH;
        BK_LENH: st_nxt = BK_LENL;
        BK_LENL: st_nxt = BK_DATA;
        BK_DATA: st_nxt = cmd.crc_tail ? BK_CRCH : BK_CMD;
        BK_CRCH: st_nxt = BK_CRCL;
        default: st_nxt = BK_CMD;
      endcase
    end
  end

  // outputs of the current step
  always_comb begin
    byte_v   = 8'h00;
    eof_v    = 1'b0;
    status_v = ST_OK;
    feed     = 1'b0;
    restart  = 1'b0;
    case (st_r)
      BK_CMD: begin
        case (cmd.kind)
          CMD_HEAD: begin
            byte_v  = start_byte;
            feed    = 1'b1;
            restart = 1'b1;
          end
          CMD_DATA: begin
            byte_v = cmd.data;
            feed   = 1'b1;
          end
          default: begin
            eof_v    = 1'b1;
            status_v = cmd.status;
          end
        endcase
      end
      BK_TYPE: begin
        byte_v = cmd.ftype;
        feed   = 1'b1;
      end
      BK_LENH: begin
        byte_v = {6'd0, cmd.flen[9:8]};
        feed   = 1'b1;
      end
      BK_LENL: begin
        byte_v = cmd.flen[7:0];
        feed   = 1'b1;
      end
      BK_DATA: begin
        byte_v = cmd.data;
        feed   = 1'b1;
      end
      BK_CRCH: byte_v = crc_r[15:8];
      BK_CRCL: begin
        byte_v = crc_r[7:0];
        eof_v  = 1'b1;
      end
      default: byte_v = 8'h00;
    endcase
  end

  assign q_pop = fire && st_nxt == BK_CMD;

  always_comb begin
    crc_nxt = crc_r;
    if (fire && feed) begin
      crc_nxt = crc_feed(restart ? CRC_INIT : crc_r, byte_v);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= BK_CMD;
      crc_r       <= CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      crc_r <= crc_nxt;
      if (slot_free) begin
        out_valid_r <= fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      byte_r   <= byte_v;
      eof_r    <= eof_v;
      status_r <= status_v;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_byte     = byte_r;
  assign out_ch.end_of_frame = eof_r;
  assign out_ch.status       = status_r;

  a_crc_closes: assert property (@(posedge clk) disable iff (!rst_n)
    fire && st_r == BK_CRCL |=> st_r == BK_CMD)
    else $error("sequencer did not return after the CRC");

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r != ST_OK |-> eof_r && byte_r == 8'h00)
    else $error("error result malformed");

endmodule
`default_nettype wire

// ===== rtl/frame_builder_crc16_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// frame_builder_crc16_top
// Length-prefixed frame builder with CRC-16/CCITT-FALSE trailer.
// ----------------------------------------------------------------------------
// On an idle block the first result of an item is registered in the command
//   queue and then in the output register before it is valid.
// Throughput: one output byte per cycle while the output port is ready;
//   payload bytes at one per cycle while the queue has room. A start item
//   makes 5 bytes, a last item 2 more (CRC): the 4-entry queue absorbs it.
// Reset (rst_n low, synchronous): closes any frame, empties the queue and the
//   output register, and sets the start byte to 0xAA. No clearing pass.
// ----------------------------------------------------------------------------
module frame_builder_crc16_top import fb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  fb_in_if.sink     in_ch,
  fb_out_if.source  out_ch,
  fb_cfg_if.sink    cfg_ch
);

  logic [7:0] start_byte_r;
  cmd_t       push_cmd;
  cmd_t       head_cmd;
  logic       push;
  logic       q_full;
  logic       q_pop;
  logic       q_valid;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= START_RESET;
    end else if (cfg_ch.valid) begin
      start_byte_r <= cfg_ch.data;
    end
  end

  fb_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cmd    (push_cmd),
    .push   (push),
    .q_full (q_full)
  );

  fb_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head       (head_cmd),
    .head_valid (q_valid)
  );

  fb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (head_cmd),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .start_byte (start_byte_r),
    .out_ch     (out_ch)
  );

endmodule
`default_nettype wire

// ===== tb/frame_builder_crc16_top_test.sv =====
// ----------------------------------------------------------------------------
// frame_builder_crc16_top_test
// Self-checking bench for the frame builder. Sends payload bytes, predicts
// every frame byte, CRC byte and error result, and compares them as they
// leave the block. Directed cases cover header and sequence errors. Random
// traffic mixes clean frames, broken frames and stray items, with
// start byte changes and gaps on both sides; a directed case adds a long output stall.
// ----------------------------------------------------------------------------
module frame_builder_crc16_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fb_pkg::*;

  localparam int LONG_HOLD_CYCLES = 80;
  localparam int WATCHDOG_LIMIT   = 3000;
  localparam int RANDOM_ITEMS     = 280;
  localparam int DRAIN_SLACK      = 16;
  localparam int MAX_REPORTS      = 10;

  typedef enum int {
    FLAW_NONE,
    FLAW_EARLY_LAST,
    FLAW_NO_LAST,
    FLAW_EXTRA
  } frame_flaw_t;

  typedef struct packed {
    logic [7:0] value;
    logic       eof;
    status_t    status;
  } frame_byte_t;

  logic clk = 1'b0;
  logic rst_n;

  fb_in_if  in_ch();
  fb_out_if out_ch();
  fb_cfg_if cfg_ch();

  frame_builder_crc16_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #4 clk = ~clk;

  // Predictor state
  logic [7:0]  sof_byte          = START_RESET;
  logic [15:0] crc_run           = CRC_INIT;
  logic [9:0]  payload_remaining = '0;
  logic        frame_active      = 1'b0;

  frame_byte_t expected_frame_bytes[$];
  int fail_count     = 0;
  int items_accepted = 0;
  bit steady         = 1'b0;
  bit hold_req       = 1'b0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    else if (r < 93) return $urandom_range(1, 3);
    else return $urandom_range(8, 30);
  endfunction

  function automatic void push_error(status_t code);
    expected_frame_bytes.push_back('{value: 8'h00, eof: 1'b1, status: code});
  endfunction

  function automatic void push_data(logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = crc_run[15] ^ b[i];
      crc_run = {crc_run[14:0], 1'b0};
      if (fb) crc_run = crc_run ^ CRC_POLY;
    end
    expected_frame_bytes.push_back('{value: b, eof: 1'b0, status: ST_OK});
  endfunction

  function automatic void close_model();
    frame_active = 1'b0;
    payload_remaining = '0;
    crc_run = CRC_INIT;
  endfunction

  function automatic void push_crc();
    expected_frame_bytes.push_back('{value: crc_run[15:8], eof: 1'b0, status: ST_OK});
    expected_frame_bytes.push_back('{value: crc_run[7:0], eof: 1'b1, status: ST_OK});
    close_model();
  endfunction

  function automatic void predict_frame_output(bit first, bit last, logic [7:0] ftype,
                                               logic [9:0] flen, logic [7:0] data);
    if (first) begin
      if (flen == 0) push_error(ST_ZERO_LEN);
      else if (frame_active) push_error(ST_OPEN);
      else if (HDR_BYTES + flen + CRC_BYTES > FRAME_MAX) push_error(ST_TOO_LONG);
      else if (last && flen != 1) push_error(ST_MISMATCH);
      else begin
        frame_active = 1'b1;
        crc_run = CRC_INIT;
        push_data(sof_byte);
        push_data(ftype);
        push_data({6'b0, flen[9:8]});
        push_data(flen[7:0]);
        push_data(data);
        payload_remaining = flen - 10'd1;
        if (last) push_crc();
      end
    end else if (!frame_active) begin
      push_error(ST_MISMATCH);
    end else if (payload_remaining == 0 || (last && payload_remaining != 1)) begin
      close_model();
      push_error(ST_MISMATCH);
    end else begin
      push_data(data);
      payload_remaining = payload_remaining - 10'd1;
      if (last) push_crc();
    end
  endfunction

  // Hold valid high after the transaction; the next item or a drain replaces it.
  task automatic send_item(bit first, bit last, logic [7:0] ftype, logic [9:0] flen,
                           logic [7:0] data);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.first      <= first;
    in_ch.last       <= last;
    in_ch.frame_type <= ftype;
    in_ch.frame_len  <= flen;
    in_ch.data_byte  <= data;
    do @(posedge clk); while (!in_ch.ready);
    items_accepted++;
    predict_frame_output(first, last, ftype, flen, data);
  endtask

  task automatic send_frame(int len, logic [7:0] ftype, frame_flaw_t flaw);
    int cut;
    bit lst;
    cut = (flaw == FLAW_EARLY_LAST && len > 1) ? $urandom_range(0, len - 2) : len - 1;
    for (int i = 0; i <= cut; i++) begin
      lst = (i == cut) && (flaw == FLAW_NONE || flaw == FLAW_EARLY_LAST);
      send_item(i == 0, lst, (i == 0) ? ftype : 8'($urandom_range(0, 255)),
                (i == 0) ? 10'(len) : 10'($urandom_range(0, 1023)),
                8'($urandom_range(0, 255)));
    end
    if (flaw == FLAW_NO_LAST || flaw == FLAW_EXTRA)
      send_item(1'b0, flaw == FLAW_NO_LAST, 8'($urandom_range(0, 255)),
                10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)));
  endtask

  task automatic drain_frames();
    in_ch.valid <= 1'b0;
    while (expected_frame_bytes.size() != 0) @(posedge clk);
  endtask

  task automatic write_start_byte(logic [7:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sof_byte = value;
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 8);
    else if (r < 97) return $urandom_range(9, 40);
    else return $urandom_range(41, 100);
  endfunction

  task automatic test_single_byte_frames();
    send_item(1'b1, 1'b1, 8'h00, 10'd1, 8'hFF);
    send_item(1'b1, 1'b1, 8'hFF, 10'd1, 8'h00);
  endtask

  task automatic test_header_errors();
    send_item(1'b1, 1'b1, 8'hFF, 10'd0, 8'h00);
    send_item(1'b1, 1'b0, 8'h00, 10'd1023, 8'hFF);
    send_item(1'b1, 1'b0, 8'h7E, 10'd1019, 8'h81);
    send_item(1'b1, 1'b1, 8'h01, 10'd2, 8'h10);
    // largest legal frame: header goes out, then an early last closes it
    send_item(1'b1, 1'b0, 8'hC3, 10'd1018, 8'h55);
    send_item(1'b0, 1'b1, 8'hAA, 10'd0, 8'h66);
    // a second start inside an open frame must leave that frame intact
    send_item(1'b1, 1'b0, 8'h42, 10'd3, 8'h01);
    send_item(1'b1, 1'b0, 8'h43, 10'd2, 8'h02);
    send_item(1'b1, 1'b0, 8'h44, 10'd0, 8'h03);
    send_item(1'b0, 1'b0, 8'h00, 10'd0, 8'h04);
    send_item(1'b0, 1'b1, 8'h00, 10'd0, 8'h05);
  endtask

  task automatic test_sequence_errors();
    send_item(1'b0, 1'b0, 8'h12, 10'd5, 8'h34);
    send_item(1'b0, 1'b1, 8'h56, 10'd1, 8'h78);
    send_frame(3, 8'h21, FLAW_EARLY_LAST);
    send_frame(2, 8'h22, FLAW_NO_LAST);
    send_frame(2, 8'h23, FLAW_EXTRA);
  endtask

  task automatic test_start_byte();
    drain_frames();
    write_start_byte(8'h00);
    send_item(1'b1, 1'b1, 8'h11, 10'd1, 8'h22);
    drain_frames();
    write_start_byte(8'hFF);
    send_frame(2, 8'h33, FLAW_NONE);
    drain_frames();
    write_start_byte(8'($urandom_range(0, 255)));
    send_frame(3, 8'h44, FLAW_NONE);
  endtask

  task automatic test_output_backpressure();
    hold_req = 1'b1;
    steady   = 1'b1;
    send_frame(20, 8'h3C, FLAW_NONE);
    steady = 1'b0;
    drain_frames();
  endtask

  task automatic test_random_traffic();
    int start_count;
    int r;
    int sel;
    start_count = items_accepted;
    while (items_accepted - start_count < RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 7) == 0);
      r = $urandom_range(0, 99);
      if (r < 4) begin
        drain_frames();
        sel = $urandom_range(0, 2);
        write_start_byte(sel == 0 ? 8'h00 : sel == 1 ? 8'hFF : 8'($urandom_range(0, 255)));
        // use the new start byte right away
        send_frame(pick_len(), 8'($urandom_range(0, 255)), FLAW_NONE);
      end else if (r < 72) begin
        send_frame(pick_len(), 8'($urandom_range(0, 255)), FLAW_NONE);
      end else if (r < 87) begin
        send_frame(pick_len(), 8'($urandom_range(0, 255)),
                   frame_flaw_t'($urandom_range(FLAW_EARLY_LAST, FLAW_EXTRA)));
      end else begin
        sel = $urandom_range(0, 3);
        send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  8'($urandom_range(0, 255)),
                  sel == 0 ? 10'd0 : sel == 1 ? 10'($urandom_range(1, 8)) :
                  sel == 2 ? 10'($urandom_range(1019, 1023)) : 10'($urandom_range(0, 1023)),
                  8'($urandom_range(0, 255)));
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.first      <= 1'b0;
    in_ch.last       <= 1'b0;
    in_ch.frame_type <= '0;
    in_ch.frame_len  <= '0;
    in_ch.data_byte  <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.data      <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_single_byte_frames();
    test_header_errors();
    test_sequence_errors();
    test_start_byte();
    test_output_backpressure();
    test_random_traffic();

    drain_frames();
    repeat (DRAIN_SLACK) @(posedge clk);
    if (fail_count == 0 && expected_frame_bytes.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Output ready: random stalls, a long hold on request, otherwise always ready when steady.
  initial begin
    int idle_left;
    idle_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else if (idle_left > 0 && !steady) begin
        out_ch.ready <= 1'b0;
        idle_left--;
      end else begin
        out_ch.ready <= 1'b1;
        idle_left = steady ? 0 : pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    frame_byte_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_frame_bytes.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("ERROR: unexpected result byte %02h eof %0b status %0d",
                   out_ch.out_byte, out_ch.end_of_frame, out_ch.status);
      end else begin
        want = expected_frame_bytes.pop_front();
        if (out_ch.out_byte !== want.value || out_ch.end_of_frame !== want.eof ||
            out_ch.status !== want.status) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("ERROR: got byte %02h eof %0b status %0d, expected byte %02h eof %0b status %0d",
                     out_ch.out_byte, out_ch.end_of_frame, out_ch.status,
                     want.value, want.eof, want.status);
        end
      end
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/fb_pkg.sv
rtl/fb_in_if.sv
rtl/fb_out_if.sv
rtl/fb_cfg_if.sv
rtl/fb_front.sv
rtl/fb_cmd_fifo.sv
rtl/fb_back.sv
rtl/frame_builder_crc16_top.sv
tb/frame_builder_crc16_top_test.sv
